/* sv/fsl_pkg.sv */
// ----------------------------------------------------------------------------
// fsl_pkg
// Shared types, constants and helpers of the frame slew limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package fsl_pkg;

    // Frame length in samples. It must be a power of two between 4 and 64,
    // because the frame average and the ramp points are taken by a shift.
    localparam int FRAME_LEN = 32;
    localparam int SHIFT     = $clog2(FRAME_LEN);
    localparam int POS_W     = SHIFT;
    localparam int MUL_W     = POS_W + 1;

    // Sample, step and accumulator widths.
    localparam int SMP_W  = 24;
    localparam int STEP_W = SMP_W + 1;
    localparam int LIM_W  = 23;
    localparam int SUM_W  = SMP_W + SHIFT;
    localparam int PROD_W = STEP_W + MUL_W + 1;
    localparam int SAT_W  = PROD_W + 1;

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    // Configuration port.
    localparam int APB_DW = 32;
    localparam int APB_AW = 3;
    localparam int MODE_W = 2;

    // Register indexes.
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_STEP = 1'b1;

    // Direction modes. The unused code behaves like limiting both ways.
    localparam logic [MODE_W-1:0] MODE_RISE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BOTH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FALL = 2'd2;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_BOTH;
    localparam logic [LIM_W-1:0]  STEP_RESET = '1;

    localparam logic signed [SAT_W-1:0] Q_MAX = SAT_W'(8388607);
    localparam logic signed [SAT_W-1:0] Q_MIN = -SAT_W'(8388608);

    // One unit of work for the back: ramp start, ramp step and the point
    // number (one to FRAME_LEN) within the frame.
    typedef struct packed {
        logic signed [SMP_W-1:0]  held;
        logic signed [STEP_W-1:0] step;
        logic [MUL_W-1:0]         mult;
    } t_work;

    // Saturate a wide signed value to the sample range.
    function automatic logic signed [SMP_W-1:0] sat_q(input logic signed [SAT_W-1:0] v);
        logic signed [SMP_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[SMP_W-1:0];
        end else if (v < Q_MIN) begin
            r = Q_MIN[SMP_W-1:0];
        end else begin
            r = v[SMP_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/fsl_front.sv */
// ----------------------------------------------------------------------------
// fsl_front
// Accepts samples, keeps the frame sum and position, and at each frame end
// forms the new held value and the limited ramp step.
// ----------------------------------------------------------------------------
`default_nettype none

module fsl_front
    import fsl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_take,
    input  wire logic signed [SMP_W-1:0] i_sample,
    input  wire logic [MODE_W-1:0]       i_mode,
    input  wire logic [LIM_W-1:0]        i_max_step,
    output t_work                        o_work
);

    logic signed [SUM_W-1:0]  r_sum,  n_sum;
    logic [POS_W-1:0]         r_pos,  n_pos;
    logic signed [SMP_W-1:0]  r_held, n_held;
    logic signed [STEP_W-1:0] r_step, n_step;

    logic                     frame_end;
    logic signed [SUM_W-1:0]  sum_all;
    logic signed [SAT_W-1:0]  end_wide;
    logic signed [SMP_W-1:0]  end_val;
    logic signed [SMP_W-1:0]  avg;
    logic signed [STEP_W-1:0] diff;
    logic signed [STEP_W-1:0] lim;
    logic signed [STEP_W-1:0] neg_lim;
    logic signed [STEP_W-1:0] limited;

    // The work handed to the back uses the state before this sample.
    assign o_work.held = r_held;
    assign o_work.step = r_step;
    assign o_work.mult = MUL_W'(r_pos) + MUL_W'(1);

    assign frame_end = (r_pos == POS_W'(FRAME_LEN - 1));
    assign sum_all   = r_sum + {{(SUM_W-SMP_W){i_sample[SMP_W-1]}}, i_sample};

    // The last ramp point of a frame is held plus the full step.
    assign end_wide = {{(SAT_W-SMP_W){r_held[SMP_W-1]}}, r_held}
                    + {{(SAT_W-STEP_W){r_step[STEP_W-1]}}, r_step};
    assign end_val  = sat_q(end_wide);

    // Frame average, rounded toward minus infinity, and its distance.
    assign avg     = sum_all[SUM_W-1:SHIFT];
    assign diff    = {avg[SMP_W-1], avg} - {end_val[SMP_W-1], end_val};
    assign lim     = {{(STEP_W-LIM_W){1'b0}}, i_max_step};
    assign neg_lim = -lim;

    // Limit the change in the directions the mode selects.
    always_comb begin
        limited = diff;
        case (i_mode)
            MODE_RISE: begin
                if (diff > lim) limited = lim;
            end
            MODE_FALL: begin
                if (diff < neg_lim) limited = neg_lim;
            end
            default: begin
                if (diff > lim) begin
                    limited = lim;
                end else if (diff < neg_lim) begin
                    limited = neg_lim;
                end
            end
        endcase
    end

    // Next frame state.
    always_comb begin
        n_sum  = r_sum;
        n_pos  = r_pos;
        n_held = r_held;
        n_step = r_step;
        if (i_take) begin
            if (frame_end) begin
                n_sum  = '0;
                n_pos  = '0;
                n_held = end_val;
                n_step = limited;
            end else begin
                n_sum = sum_all;
                n_pos = r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_pos  <= '0;
            r_held <= '0;
            r_step <= '0;
        end else begin
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_held <= n_held;
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* sv/fsl_queue.sv */
// ----------------------------------------------------------------------------
// fsl_queue
// Short register queue of work items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module fsl_queue
    import fsl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr,
    input  wire t_work i_data,
    output logic       o_full,
    input  wire logic  i_rd,
    output t_work      o_data,
    output logic       o_empty
);

    t_work             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QPTR_W:0]   r_cnt, n_cnt;
    logic              wr_en;
    logic              rd_en;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    assign wr_en = i_wr && !o_full;
    assign rd_en = i_rd && !o_empty;

    // Pointer and fill count update.
    always_comb begin
        n_wp  = wr_en ? r_wp + QPTR_W'(1) : r_wp;
        n_rp  = rd_en ? r_rp + QPTR_W'(1) : r_rp;
        n_cnt = r_cnt;
        if (wr_en && !rd_en) begin
            n_cnt = r_cnt + (QPTR_W+1)'(1);
        end else if (rd_en && !wr_en) begin
            n_cnt = r_cnt - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

`default_nettype wire

/* sv/fsl_back.sv */
// ----------------------------------------------------------------------------
// fsl_back
// Computes each ramp point from a work item and holds the result in the
// output register until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module fsl_back
    import fsl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_work                   i_work,
    input  wire logic                    i_work_empty,
    output logic                         o_work_rd,
    input  wire logic                    i_pop,
    output logic                         o_empty,
    output logic signed [SMP_W-1:0]      o_sample
);

    logic                     r_valid, n_valid;
    logic signed [SMP_W-1:0]  r_out;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] part;
    logic signed [SAT_W-1:0]  point;

    // Take a new work item when the output register is free or drains now.
    assign o_work_rd = !i_work_empty && (!r_valid || i_pop);

    // held + floor(step * (k+1) / FRAME_LEN), then saturate.
    assign prod  = i_work.step * $signed({1'b0, i_work.mult});
    assign part  = prod >>> SHIFT;
    assign point = {{(SAT_W-SMP_W){i_work.held[SMP_W-1]}}, i_work.held}
                 + {part[PROD_W-1], part};

    always_comb begin
        n_valid = r_valid;
        if (o_work_rd) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_work_rd) begin
            r_out <= sat_q(point);
        end
    end

    assign o_empty  = !r_valid;
    assign o_sample = r_out;

endmodule

`default_nettype wire

/* sv/frame_slew_limiter.sv */
// ----------------------------------------------------------------------------
// frame_slew_limiter
// Frame based slew-rate limiter on a signed Q4.20 sample stream.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while not full and gives one result per sample, in
// order. Samples are summed over frames of FRAME_LEN; at each frame end the
// frame average is compared with the held value and the change is limited to
// max_step (rising only, both ways or falling only), then ramped in linearly
// over the next frame, so the output lags by one frame and the first frame
// after reset is zero. A sample is classified by the front in the cycle it is
// accepted, waits in a four-entry queue and is turned into its ramp point by
// the back's single multiplier, so one item enters and one leaves per cycle
// when nothing stalls; each result waits in the back's output register until it
// is taken.
// Registers: direction_mode at byte address 0, max_step at byte address 4.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_slew_limiter
    import fsl_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    // Sample input
    input  wire logic                    push,
    output logic                         full,
    input  wire logic signed [SMP_W-1:0] i_in_sample,
    // Result output
    input  wire logic                    pop,
    output logic                         empty,
    output logic signed [SMP_W-1:0]      o_out_sample,
    // Configuration port
    input  wire logic                    psel,
    input  wire logic                    penable,
    input  wire logic                    pwrite,
    input  wire logic [APB_AW-1:0]       paddr,
    input  wire logic [APB_DW-1:0]       pwdata,
    output logic [APB_DW-1:0]            prdata,
    output logic                         pready
);

    logic [MODE_W-1:0] r_mode;
    logic [LIM_W-1:0]  r_max_step;
    logic              cfg_wr;
    logic              take;
    t_work             front_work;
    t_work             back_work;
    logic              work_empty;
    logic              work_rd;

    // Configuration registers; word addresses ignore the low address bits.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_RESET;
            r_max_step <= STEP_RESET;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_MODE: r_mode     <= pwdata[MODE_W-1:0];
                REG_STEP: r_max_step <= pwdata[LIM_W-1:0];
                default:  r_mode     <= r_mode;
            endcase
        end
    end

    // Register read back.
    always_comb begin
        unique case (paddr[2])
            REG_MODE: prdata = {{(APB_DW-MODE_W){1'b0}}, r_mode};
            REG_STEP: prdata = {{(APB_DW-LIM_W){1'b0}}, r_max_step};
            default:  prdata = '0;
        endcase
    end

    assign take = push && !full;

    fsl_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_sample   (i_in_sample),
        .i_mode     (r_mode),
        .i_max_step (r_max_step),
        .o_work     (front_work)
    );

    fsl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (take),
        .i_data  (front_work),
        .o_full  (full),
        .i_rd    (work_rd),
        .o_data  (back_work),
        .o_empty (work_empty)
    );

    fsl_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work       (back_work),
        .i_work_empty (work_empty),
        .o_work_rd    (work_rd),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_sample     (o_out_sample)
    );

endmodule

`default_nettype wire

/* test/frame_slew_limiter_tb.sv */
// ----------------------------------------------------------------------------
// frame_slew_limiter_tb
// Self-checking testbench for the frame based slew-rate limiter.
// ----------------------------------------------------------------------------
// Samples go in through the push/full queue port and results come out through
// the empty/pop port. A predictor tracks the frame sum, the held value and the
// ramp step, and forms the expected ramp point for every accepted item. The
// run checks the register reset values, then sends a short burst of extreme
// samples. It then sweeps the direction modes and step limits, including the
// unused mode code and the smallest and largest limits. Last, it holds the
// output back for a long stretch so that the block fills up and stalls its
// input. Output stalls are random throughout; input gaps are random in most phases.
// ----------------------------------------------------------------------------
module frame_slew_limiter_tb;
    import fsl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int     HALF_PERIOD = 2;
    localparam int     RESET_CYCLES = 6;
    localparam int     IDLE_LIMIT = 3000;
    localparam int     LONG_HOLD = 400;
    localparam int     SETTLE_CYCLES = 4;
    localparam int     SWEEP_PHASES = 11;
    localparam int     FRAMES_PER_PHASE = 4;
    localparam longint SAMPLE_HI = 64'sd8388607;
    localparam longint SAMPLE_LO = -64'sd8388608;

    // The fourth mode code has no name in the package; it limits both ways.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    // Block ports.
    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    push = 1'b0;
    logic                    full;
    logic signed [SMP_W-1:0] i_in_sample = '0;
    logic                    pop = 1'b0;
    logic                    empty;
    logic signed [SMP_W-1:0] o_out_sample;
    logic                    psel = 1'b0;
    logic                    penable = 1'b0;
    logic                    pwrite = 1'b0;
    logic [APB_AW-1:0]       paddr = '0;
    logic [APB_DW-1:0]       pwdata = '0;
    logic [APB_DW-1:0]       prdata;
    logic                    pready;

    // Predicted state of the limiter.
    logic [MODE_W-1:0]        mode_q = MODE_RESET;
    logic [LIM_W-1:0]         limit_q = STEP_RESET;
    longint                   frame_acc = 0;
    int                       frame_pos = 0;
    logic signed [SMP_W-1:0]  held_q = '0;
    logic signed [STEP_W-1:0] ramp_q = '0;

    // Ramp points still owed by the block, oldest first.
    logic signed [SMP_W-1:0] ramp_points_q[$];
    logic signed [SMP_W-1:0] want_point;

    int mismatch_count = 0;
    int samples_sent = 0;
    int settings_count = 0;
    int idle_cycles = 0;

    // Sender burst state.
    int burst_left = 0;
    bit gaps_on = 1'b1;

    // Receiver stall pattern and long hold-off.
    int pattern_left = 0;
    int rx_style = 0;
    int hold_left = 0;
    int hold_asked = 0;
    int hold_granted = 0;

    frame_slew_limiter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_sample (i_in_sample),
        .pop         (pop),
        .empty       (empty),
        .o_out_sample(o_out_sample),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Advance the predictor by one sample and return the ramp point it emits.
    function automatic logic signed [SMP_W-1:0] next_ramp_point(
        input logic signed [SMP_W-1:0] x
    );
        longint                  point;
        longint                  avg;
        longint                  delta;
        longint                  lim;
        logic signed [SMP_W-1:0] y;
        point = longint'(held_q) + ((longint'(ramp_q) * longint'(frame_pos + 1)) >>> SHIFT);
        if (point > SAMPLE_HI) begin
            point = SAMPLE_HI;
        end else if (point < SAMPLE_LO) begin
            point = SAMPLE_LO;
        end
        y = SMP_W'(point);
        frame_acc += longint'(x);
        if (frame_pos == FRAME_LEN - 1) begin
            // Frame end: the last ramp point becomes the new start.
            held_q = y;
            avg = frame_acc >>> SHIFT;
            delta = avg - longint'(held_q);
            lim = longint'(limit_q);
            case (mode_q)
                MODE_RISE: begin
                    if (delta > lim) delta = lim;
                end
                MODE_FALL: begin
                    if (delta < -lim) delta = -lim;
                end
                default: begin
                    if (delta > lim) delta = lim;
                    if (delta < -lim) delta = -lim;
                end
            endcase
            ramp_q = STEP_W'(delta);
            frame_acc = 0;
            frame_pos = 0;
        end else begin
            frame_pos++;
        end
        return y;
    endfunction

    // Offer one sample and wait until the block takes it. Called at a rising edge.
    task automatic send_sample(input logic signed [SMP_W-1:0] s);
        int gap;
        bit taken;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 6);
                push <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        push <= 1'b1;
        i_in_sample <= s;
        do begin
            @(negedge i_clk);
            taken = !full;
            if (taken) begin
                ramp_points_q.push_back(next_ramp_point(s));
                samples_sent++;
            end
            @(posedge i_clk);
        end while (!taken);
    endtask

    // Stop sending and wait until every owed result has been taken.
    task automatic drain_results();
        push <= 1'b0;
        while (ramp_points_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write over the configuration port. Called at a rising edge.
    task automatic write_register(input logic idx, input logic [APB_DW-1:0] value);
        bit done;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_MODE) begin
            mode_q = value[MODE_W-1:0];
        end else begin
            limit_q = value[LIM_W-1:0];
        end
        @(posedge i_clk);
    endtask

    // Register read, compared with the value the predictor holds.
    task automatic check_register(input logic idx);
        bit                done;
        logic [APB_DW-1:0] got;
        logic [APB_DW-1:0] want;
        want = (idx == REG_MODE) ? APB_DW'(mode_q) : APB_DW'(limit_q);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            got = prdata;
            @(posedge i_clk);
        end while (!done);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: register %0d read expected %0d, actual %0d",
                     $time, idx, want, got);
        end
        @(posedge i_clk);
    endtask

    // One frame of samples of a random character.
    task automatic send_frame();
        int                      kind;
        logic signed [SMP_W-1:0] level;
        logic signed [SMP_W-1:0] s;
        kind = $urandom_range(0, 6);
        level = SMP_W'($urandom());
        for (int i = 0; i < FRAME_LEN; i++) begin
            case (kind)
                0, 1, 2: s = level ^ SMP_W'($urandom_range(0, 255));
                3:       s = SMP_W'(SAMPLE_HI);
                4:       s = SMP_W'(SAMPLE_LO);
                5:       s = SMP_W'($urandom());
                default: s = i[0] ? SMP_W'(SAMPLE_HI) : SMP_W'(SAMPLE_LO);
            endcase
            send_sample(s);
        end
    endtask

    // Registers come out of reset at their documented values.
    task automatic test_register_reset();
        check_register(REG_MODE);
        check_register(REG_STEP);
    endtask

    // Extreme and bit-pattern samples; the first frame must give zeros.
    task automatic test_directed_extremes();
        logic signed [SMP_W-1:0] s;
        for (int i = 0; i < 24; i++) begin
            case (i % 6)
                0:       s = SMP_W'(SAMPLE_HI);
                1:       s = SMP_W'(SAMPLE_LO);
                2:       s = '0;
                3:       s = -24'sd1;
                4:       s = 24'sd1;
                default: s = i[0] ? 24'h555555 : 24'hAAAAAA;
            endcase
            send_sample(s);
        end
    endtask

    // Walk through direction modes and step limits, several frames each.
    task automatic test_setting_sweep();
        logic [MODE_W-1:0] m;
        logic [LIM_W-1:0]  lim;
        for (int p = 0; p < SWEEP_PHASES; p++) begin
            case (p)
                0: begin m = MODE_RISE;   lim = '0;         end
                1: begin m = MODE_FALL;   lim = STEP_RESET; end
                2: begin m = MODE_BOTH;   lim = '0;         end
                3: begin m = MODE_UNUSED; lim = LIM_W'($urandom_range(1, 4096)); end
                4: begin m = MODE_RISE;   lim = STEP_RESET; end
                5: begin m = MODE_FALL;   lim = '0;         end
                default: begin
                    m = MODE_W'($urandom_range(0, 3));
                    lim = $urandom_range(0, 1) ? LIM_W'($urandom_range(0, 8191))
                                               : LIM_W'($urandom());
                end
            endcase
            drain_results();
            write_register(REG_MODE, APB_DW'(m));
            write_register(REG_STEP, APB_DW'(lim));
            check_register(REG_MODE);
            check_register(REG_STEP);
            settings_count++;
            gaps_on = (p % 3) != 0;
            for (int f = 0; f < FRAMES_PER_PHASE; f++) send_frame();
        end
    endtask

    // Hold the output back while samples keep coming, so the input stalls.
    task automatic test_stall_backpressure();
        gaps_on = 1'b0;
        hold_asked++;
        for (int f = 0; f < 3; f++) send_frame();
        gaps_on = 1'b1;
    endtask

    // Receiver: random stall styles, plus one long hold-off when asked.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            pop <= 1'b0;
        end else if (hold_asked != hold_granted) begin
            hold_granted <= hold_granted + 1;
            hold_left <= LONG_HOLD;
            pop <= 1'b0;
        end else begin
            if (pattern_left == 0) begin
                pattern_left <= $urandom_range(20, 200);
                rx_style <= $urandom_range(0, 3);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (rx_style)
                0:       pop <= 1'b1;
                1:       pop <= $urandom_range(0, 3) != 0;
                2:       pop <= $urandom_range(0, 3) == 0;
                default: pop <= ~pop;
            endcase
        end
    end

    // Compare each result taken with the oldest owed ramp point.
    always @(negedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (ramp_points_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, actual %0d", $time, o_out_sample);
            end else begin
                want_point = ramp_points_q.pop_front();
                if (o_out_sample !== want_point) begin
                    mismatch_count++;
                    $display("%0t: out_sample expected %0d, actual %0d",
                             $time, want_point, o_out_sample);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    always @(negedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_register_reset();
        test_directed_extremes();
        test_setting_sweep();
        test_stall_backpressure();
        drain_results();
        $display("Checked %0d samples (%0d full frames) under %0d register settings,",
                 samples_sent, samples_sent / FRAME_LEN, settings_count);
        $display("with random input gaps, output stalls and one long output hold-off.");
        if (mismatch_count == 0 && ramp_points_q.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
